// File: rtl/krrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krrl_pkg
// Types and constants shared by the keyed request rate limiter and its checker.
// ----------------------------------------------------------------------------
package krrl_pkg;

  localparam int unsigned KEY_COUNT = 256;
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 2'd2;

  // request functions
  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // policy modes
  localparam logic MODE_TOKEN  = 1'b0;
  localparam logic MODE_WINDOW = 1'b1;

  // register reset values
  localparam logic        RST_POLICY_MODE    = MODE_WINDOW;
  localparam logic [15:0] RST_MAX_REQUESTS   = 16'd100;
  localparam logic [15:0] RST_WINDOW_SECONDS = 16'd60;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key_index;
    logic [31:0]      now_seconds;
  } req_t;

  typedef struct packed {
    logic        allowed;
    logic [15:0] remaining;
    logic [15:0] retry_after;
    logic [32:0] reset_time;
  } rsp_t;

  typedef struct packed {
    logic [15:0] bucket_tokens;
    logic [31:0] bucket_last_time;
    logic [31:0] window_start;
    logic [16:0] window_count;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_CALC = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_FIN  = 7'b0010000,
    S_DIV2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

endpackage

// File: rtl/keyed_request_rate_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_request_rate_limiter
// Per-key request policing with token bucket or counting window policy.
// ----------------------------------------------------------------------------
// One request is handled at a time. Per-key state lives in a 256-entry
// single-port memory with registered read; each entry has a valid bit that
// reset clears at once, so the block is ready right after reset with no
// clearing pass. A clear request goes from idle straight to output, a
// window-mode check through read, calc and output. A token-mode check skips
// the divider once a full window has elapsed and else runs the 32-step
// serial divider that scales the refill; a denied token check with a nonzero
// capacity runs it again for the retry delay. The result sits in an output
// register, and the next request is taken while it waits there.
module keyed_request_rate_limiter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  krrl_pkg::req_t                  in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output krrl_pkg::rsp_t                  out_rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [krrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [krrl_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  krrl_pkg::state_e state_q, state_d;

  logic        mode_q;
  logic [15:0] max_q;
  logic [15:0] win_q;

  logic                           out_valid_q, out_valid_d;
  krrl_pkg::rsp_t                 out_rsp_q, out_rsp_d;
  krrl_pkg::rsp_t                 res_q, res_d;
  krrl_pkg::req_t                 req_q, req_d;
  logic [15:0]                    elapsed_q, elapsed_d;
  logic                           full_q, full_d;
  logic                           restart_q, restart_d;
  logic [32:0]                    end_old_q, end_old_d;
  logic [32:0]                    end_now_q, end_now_d;
  logic [31:0]                    quo_q, quo_d;
  logic [15:0]                    rem_q, rem_d;
  logic [15:0]                    dvs_q, dvs_d;
  logic [krrl_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  krrl_pkg::entry_t               mem [krrl_pkg::KEY_COUNT];
  krrl_pkg::entry_t               rdata_q;
  logic                           rd_vld_q;
  logic [krrl_pkg::KEY_COUNT-1:0] vld_q;
  logic                           mem_re, mem_we, vld_clr;
  krrl_pkg::entry_t               mem_wdata;
  krrl_pkg::entry_t               ent;

  logic        in_acc;
  logic [31:0] elapsed32;
  logic [16:0] rem_sh;
  logic        div_ge;
  logic [16:0] win_cnt;
  logic [16:0] win_cap;
  logic [16:0] win_sat;
  logic        win_ok;
  logic [16:0] tok_sum;
  logic [16:0] tok_cap;
  logic [15:0] tok;

  assign in_ready_o  = (state_q == krrl_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign ent = rd_vld_q ? rdata_q : '0;

  // shared restoring divider step
  assign rem_sh = {rem_q, quo_q[31]};
  assign div_ge = (rem_sh >= {1'b0, dvs_q});

  assign elapsed32 = (req_q.now_seconds >= ent.bucket_last_time)
                   ? (req_q.now_seconds - ent.bucket_last_time) : 32'd0;

  assign win_cnt = restart_q ? 17'd1 : (ent.window_count + 17'd1);
  assign win_cap = {1'b0, max_q} + 17'd1;
  assign win_sat = (win_cnt > win_cap) ? win_cap : win_cnt;
  assign win_ok  = (win_sat <= {1'b0, max_q});

  assign tok_sum = {1'b0, ent.bucket_tokens} + {1'b0, quo_q[15:0]};
  assign tok_cap = full_q ? {1'b0, max_q}
                 : ((tok_sum < {1'b0, max_q}) ? tok_sum : {1'b0, max_q});
  assign tok     = tok_cap[15:0];

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    res_d       = res_q;
    req_d       = req_q;
    elapsed_d   = elapsed_q;
    full_d      = full_q;
    restart_d   = restart_q;
    end_old_d   = end_old_q;
    end_now_d   = end_now_q;
    quo_d       = {quo_q[30:0], div_ge};
    rem_d       = div_ge ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
    dvs_d       = dvs_q;
    cnt_d       = cnt_q - 1'b1;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    vld_clr     = 1'b0;
    mem_wdata   = ent;

    case (state_q)
      krrl_pkg::S_IDLE: begin
        cnt_d = cnt_q;
        quo_d = quo_q;
        rem_d = rem_q;
        if (in_acc) begin
          req_d = in_req_i;
          if (in_req_i.func == krrl_pkg::FUNC_CLEAR) begin
            vld_clr = 1'b1;
            res_d   = '{allowed: 1'b1, remaining: '0, retry_after: '0, reset_time: '0};
            state_d = krrl_pkg::S_OUT;
          end else begin
            mem_re  = 1'b1;
            state_d = krrl_pkg::S_READ;
          end
        end
      end
      krrl_pkg::S_READ: begin
        elapsed_d = elapsed32[15:0];
        full_d    = (elapsed32 >= {16'd0, win_q});
        end_old_d = {1'b0, ent.window_start} + {17'd0, win_q};
        end_now_d = {1'b0, req_q.now_seconds} + {17'd0, win_q};
        restart_d = (({1'b0, ent.window_start} + {17'd0, win_q})
                    < {1'b0, req_q.now_seconds});
        state_d   = krrl_pkg::S_CALC;
      end
      krrl_pkg::S_CALC: begin
        if (mode_q == krrl_pkg::MODE_TOKEN) begin
          quo_d   = elapsed_q * max_q;
          rem_d   = '0;
          dvs_d   = win_q;
          cnt_d   = krrl_pkg::DIV_CNT_W'(krrl_pkg::DIV_STEPS - 1);
          state_d = full_q ? krrl_pkg::S_FIN : krrl_pkg::S_DIV;
        end else begin
          mem_we                 = 1'b1;
          mem_wdata.window_start = restart_q ? req_q.now_seconds : ent.window_start;
          mem_wdata.window_count = win_sat;
          res_d.allowed          = win_ok;
          res_d.remaining        = win_ok ? 16'(max_q - win_sat[15:0]) : 16'd0;
          res_d.retry_after      = win_ok ? 16'd0 : win_q;
          res_d.reset_time       = restart_q ? end_now_q : end_old_q;
          state_d                = krrl_pkg::S_OUT;
        end
      end
      krrl_pkg::S_DIV: begin
        if (cnt_q == '0) begin
          state_d = krrl_pkg::S_FIN;
        end
      end
      krrl_pkg::S_FIN: begin
        mem_we                     = 1'b1;
        mem_wdata.bucket_last_time = req_q.now_seconds;
        res_d.reset_time           = '0;
        if (tok != 16'd0) begin
          mem_wdata.bucket_tokens = tok - 16'd1;
          res_d.allowed           = 1'b1;
          res_d.remaining         = tok - 16'd1;
          res_d.retry_after       = '0;
          state_d                 = krrl_pkg::S_OUT;
        end else begin
          mem_wdata.bucket_tokens = '0;
          res_d.allowed           = 1'b0;
          res_d.remaining         = '0;
          res_d.retry_after       = 16'hffff;
          if (max_q == 16'd0) begin
            state_d = krrl_pkg::S_OUT;
          end else begin
            quo_d   = {16'd0, win_q};
            rem_d   = '0;
            dvs_d   = max_q;
            cnt_d   = krrl_pkg::DIV_CNT_W'(krrl_pkg::DIV_STEPS - 1);
            state_d = krrl_pkg::S_DIV2;
          end
        end
      end
      krrl_pkg::S_DIV2: begin
        if (cnt_q == '0) begin
          res_d.retry_after = quo_d[15:0];
          state_d           = krrl_pkg::S_OUT;
        end
      end
      krrl_pkg::S_OUT: begin
        cnt_d = cnt_q;
        quo_d = quo_q;
        rem_d = rem_q;
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = krrl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = krrl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= krrl_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= krrl_pkg::RST_POLICY_MODE;
      max_q       <= krrl_pkg::RST_MAX_REQUESTS;
      win_q       <= krrl_pkg::RST_WINDOW_SECONDS;
      vld_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          krrl_pkg::CFG_POLICY_MODE:    mode_q <= cfg_data_i[0];
          krrl_pkg::CFG_MAX_REQUESTS:   max_q  <= cfg_data_i;
          krrl_pkg::CFG_WINDOW_SECONDS: win_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (mem_we) begin
        vld_q[req_q.key_index] <= 1'b1;
      end
      if (vld_clr) begin
        vld_q[in_req_i.key_index] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    res_q     <= res_d;
    req_q     <= req_d;
    elapsed_q <= elapsed_d;
    full_q    <= full_d;
    restart_q <= restart_d;
    end_old_q <= end_old_d;
    end_now_q <= end_now_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    cnt_q     <= cnt_d;
  end

  // entry store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[req_q.key_index] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q  <= mem[in_req_i.key_index];
      rd_vld_q <= vld_q[in_req_i.key_index];
    end
  end

endmodule

// File: rtl/krrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krrl_checker
// Port-level checks for the keyed request rate limiter.
// ----------------------------------------------------------------------------
module krrl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input krrl_pkg::rsp_t out_rsp_o
);

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // a result shows up only after a request was being worked on
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without pending request");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // a granted request never carries a retry delay
  a_grant_no_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.allowed |-> out_rsp_o.retry_after == 16'd0)
    else $error("allowed result with retry delay");

endmodule

bind keyed_request_rate_limiter krrl_checker u_krrl_checker (.*);
